/* rtl/skt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Table size, item layouts, op and status codes, cell command format.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH     = 256;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  // read-back OR tree: cells per group, number of groups
  localparam int GRP       = 16;
  localparam int NGRP      = (DEPTH + GRP - 1) / GRP;

  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_FIND       = 3'd1;
  localparam logic [2:0] OP_REMOVE_KEY = 3'd2;
  localparam logic [2:0] OP_REMOVE_POS = 3'd3;
  localparam logic [2:0] OP_APPEND     = 3'd4;
  localparam logic [2:0] OP_READ       = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BADPOS   = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
    logic [7:0]  position;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  found_position;
    logic [31:0] found_key;
    logic [8:0]  count;
  } out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,   // target takes key, cells above take left neighbor
    CELL_DEL,   // target and cells above take right neighbor
    CELL_APP    // target takes key
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic [IDX_W-1:0]       target;
    logic [IDX_W-1:0]       sel;
    logic [KEY_WIDTH-1:0]   key;
  } cell_cmd_t;

  // entry read back from the selected cell, with its compare flags
  typedef struct packed {
    logic                 lt;   // probe key below entry
    logic                 gt;   // probe key above entry
    logic [KEY_WIDTH-1:0] key;
  } sel_t;

endpackage

/* rtl/sorted_key_table_unit.sv */
`timescale 1ns / 1ps
// Append, bad position and unused op items go from S_START to S_DONE; read and
// remove at position run one probe; insert, find and remove key up to 9 probes.
// One item at a time; the next is accepted once the last result is registered.
// Per probe: S_SEL1 selects a cell, S_SEL2 registers its group, S_EVAL decides.
// Reset clears the entry count and the output valid; key cells are unreset.
// ----------------------------------------------------------------------------
// sorted_key_table_unit: sorted key table on a row of shifting cells
// Binary search insert, find and remove, append and positional read.
// ----------------------------------------------------------------------------
module sorted_key_table_unit import skt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  cell_cmd_t              cmd;
  logic [KEY_WIDTH-1:0]   cell_key [DEPTH];
  sel_t [NGRP*GRP-1:0]    cell_sel;
  sel_t [NGRP-1:0]        grp_sel;
  sel_t                   probe;

  for (genvar i = 0; i < NGRP * GRP; i++) begin : g_cell
    if (i < DEPTH) begin : g_live
      logic [KEY_WIDTH-1:0] left, right;
      if (i == 0) begin : g_first
        assign left = '0;
      end else begin : g_mid_l
        assign left = cell_key[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right = '0;
      end else begin : g_mid_r
        assign right = cell_key[i+1];
      end
      skt_cell u_cell (
        .clk_i   (clk_i),
        .idx_i   (IDX_W'(i)),
        .cmd_i   (cmd),
        .left_i  (left),
        .right_i (right),
        .key_o   (cell_key[i]),
        .sel_o   (cell_sel[i])
      );
    end else begin : g_pad
      assign cell_sel[i] = '0;
    end
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    skt_group u_group (
      .clk_i   (clk_i),
      .cells_i (cell_sel[g*GRP +: GRP]),
      .grp_o   (grp_sel[g])
    );
  end

  always_comb begin
    probe = '0;
    for (int g = 0; g < NGRP; g++) begin
      probe = probe | grp_sel[g];
    end
  end

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cmd_o       (cmd),
    .probe_i     (probe)
  );

endmodule

/* rtl/skt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_cell: one table entry
// Holds one key, shifts with its neighbors on insert and remove, and
// drives its key and compare flags into the read-back tree when selected.
// ----------------------------------------------------------------------------
module skt_cell import skt_pkg::*; (
  input  logic                 clk_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  cell_cmd_t            cmd_i,
  input  logic [KEY_WIDTH-1:0] left_i,
  input  logic [KEY_WIDTH-1:0] right_i,
  output logic [KEY_WIDTH-1:0] key_o,
  output sel_t                 sel_o
);

  logic [KEY_WIDTH-1:0] key_q, key_d;
  sel_t                 sel_q, sel_d;

  always_comb begin
    key_d = key_q;
    case (cmd_i.op)
      CELL_INS: begin
        if (idx_i == cmd_i.target) begin
          key_d = cmd_i.key;
        end else if (idx_i > cmd_i.target) begin
          key_d = left_i;
        end
      end
      CELL_DEL: begin
        if (idx_i >= cmd_i.target) begin
          key_d = right_i;
        end
      end
      CELL_APP: begin
        if (idx_i == cmd_i.target) begin
          key_d = cmd_i.key;
        end
      end
      default: key_d = key_q;
    endcase
  end

  always_comb begin
    sel_d = '0;
    if (idx_i == cmd_i.sel) begin
      sel_d.lt  = cmd_i.key < key_q;
      sel_d.gt  = cmd_i.key > key_q;
      sel_d.key = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    sel_q <= sel_d;
  end

  assign key_o = key_q;
  assign sel_o = sel_q;

endmodule

/* rtl/skt_group.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_group: first level of the read-back tree
// ORs the outputs of one group of cells (only the selected one is nonzero)
// into a register.
// ----------------------------------------------------------------------------
module skt_group import skt_pkg::*; (
  input  logic             clk_i,
  input  sel_t [GRP-1:0]   cells_i,
  output sel_t             grp_o
);

  sel_t grp_q, grp_d;

  always_comb begin
    grp_d = '0;
    for (int i = 0; i < GRP; i++) begin
      grp_d = grp_d | cells_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign grp_o = grp_q;

endmodule

/* rtl/skt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ctrl: operation sequencer
// Runs the binary search over the cell row one probe at a time, issues
// shift commands, tracks the entry count and holds the result register.
// ----------------------------------------------------------------------------
module skt_ctrl import skt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_t       in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_t      out_o,
  output cell_cmd_t cmd_o,
  input  sel_t      probe_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SEL1,
    S_SEL2,
    S_EVAL,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [2:0]           op_q, op_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [7:0]           pos_q, pos_d;
  logic [CNT_W-1:0]     lo_q, lo_d;
  logic [CNT_W-1:0]     hi_q, hi_d;
  logic [IDX_W-1:0]     mid_q, mid_d;
  logic [CNT_W-1:0]     count_q, count_d;
  out_t                 res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;

  logic                 srch_go;
  logic [CNT_W-1:0]     nlo, nhi;
  logic [CNT_W:0]       mid_sum;
  logic                 full;

  assign full    = count_q >= CNT_W'(DEPTH);
  assign mid_sum = {1'b0, nlo} + {1'b0, nhi};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    pos_d       = pos_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    srch_go     = 1'b0;
    nlo         = lo_q;
    nhi         = hi_q;

    cmd_o.op     = CELL_HOLD;
    cmd_o.target = mid_q;
    cmd_o.sel    = mid_q;
    cmd_o.key    = key_q;

    in_stall_o = (state_q != S_IDLE);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_i.op;
          key_d   = in_i.key[KEY_WIDTH-1:0];
          pos_d   = in_i.position;
          state_d = S_START;
        end
      end

      S_START: begin
        res_d       = '0;
        res_d.count = 9'(count_q);
        state_d     = S_DONE;
        case (op_q)
          OP_INSERT, OP_FIND, OP_REMOVE_KEY: begin
            srch_go = 1'b1;
            nlo     = '0;
            nhi     = count_q;
          end
          OP_REMOVE_POS, OP_READ: begin
            if (CNT_W'(pos_q) >= count_q) begin
              res_d.status = ST_BADPOS;
            end else begin
              mid_d   = IDX_W'(pos_q);
              state_d = S_SEL1;
            end
          end
          OP_APPEND: begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              cmd_o.op             = CELL_APP;
              cmd_o.target         = IDX_W'(count_q);
              count_d              = count_q + CNT_W'(1);
              res_d.found_position = 8'(count_q);
              res_d.found_key      = 32'(key_q);
              res_d.count          = 9'(count_d);
            end
          end
          default: res_d.status = ST_OK;
        endcase
      end

      S_SEL1: state_d = S_SEL2;
      S_SEL2: state_d = S_EVAL;

      S_EVAL: begin
        state_d = S_DONE;
        if (op_q inside {OP_REMOVE_POS, OP_READ}) begin
          res_d.found_position = 8'(mid_q);
          res_d.found_key      = 32'(probe_i.key);
          if (op_q == OP_REMOVE_POS) begin
            cmd_o.op    = CELL_DEL;
            count_d     = count_q - CNT_W'(1);
            res_d.count = 9'(count_d);
          end
        end else if (!probe_i.lt && !probe_i.gt) begin
          res_d.found_position = 8'(mid_q);
          res_d.found_key      = 32'(probe_i.key);
          if (op_q == OP_INSERT) begin
            res_d.status = ST_DUP;
          end else if (op_q == OP_REMOVE_KEY) begin
            cmd_o.op    = CELL_DEL;
            count_d     = count_q - CNT_W'(1);
            res_d.count = 9'(count_d);
          end
        end else begin
          srch_go = 1'b1;
          if (probe_i.lt) begin
            nhi = CNT_W'(mid_q);
          end else begin
            nlo = CNT_W'(mid_q) + CNT_W'(1);
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // next probe, or finish a search that ran out of range at nlo
    if (srch_go) begin
      lo_d = nlo;
      hi_d = nhi;
      if (nlo < nhi) begin
        mid_d   = mid_sum[IDX_W:1];
        state_d = S_SEL1;
      end else if (op_q == OP_INSERT) begin
        state_d = S_DONE;
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          cmd_o.op             = CELL_INS;
          cmd_o.target         = IDX_W'(nlo);
          count_d              = count_q + CNT_W'(1);
          res_d.found_position = 8'(nlo);
          res_d.found_key      = 32'(key_q);
          res_d.count          = 9'(count_d);
        end
      end else begin
        state_d      = S_DONE;
        res_d.status = ST_NOTFOUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      key_q       <= '0;
      pos_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      count_q     <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      key_q       <= key_d;
      pos_q       <= pos_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      mid_q       <= mid_d;
      count_q     <= count_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* rtl/skt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_checker: port-level checks for the sorted key table
// Result hold under stall, error result contents, full count, one item in flight.
// ----------------------------------------------------------------------------
module skt_checker import skt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("result item changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == ST_NOTFOUND || out_o.status == ST_FULL ||
                    out_o.status == ST_BADPOS)
    |-> out_o.found_position == '0 && out_o.found_key == '0)
    else $error("error result carries position or key");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == ST_FULL |-> out_o.count == 9'(DEPTH))
    else $error("table full reported below capacity");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in flight");

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

/* tb/sorted_key_table_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_unit_tb: self-checking bench for the sorted key table
// A directed table walks the empty, duplicate, bad position and unused op
// corners. It is followed by a random sweep that grows the table toward full
// and shrinks it once full. Every result is checked against a hand-written
// result or a local table predictor, with random idles and stalls on both channels.
// ----------------------------------------------------------------------------
module sorted_key_table_unit_tb import skt_pkg::*;;

  localparam int          CLK_HALF    = 5;
  localparam int          N_DIRECTED  = 24;
  localparam int          N_RANDOM    = 376;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN       = 40;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // op codes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    in_t  item;
    logic typed;   // want holds a hand-written result
    out_t want;
  } probe_row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_i        = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_o;

  // predictor state
  logic [31:0] tbl_keys [DEPTH];
  int          tbl_count;

  out_t        pending_results [$];
  probe_row_t  directed_rows [N_DIRECTED];
  int          errors;
  int          items_sent;
  int          results_checked;
  int          peak_count;
  int          status_seen [5];
  int unsigned cycle_count;
  bit          hold_req = 1'b0;

  sorted_key_table_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // probe sequence low=0, high=count, mid=(low+high)/2; slot is hit or insert point
  function automatic bit search_slot(input logic [31:0] k, output int slot);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = tbl_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (k < tbl_keys[mid]) begin
        hi = mid;
      end else if (k > tbl_keys[mid]) begin
        lo = mid + 1;
      end else begin
        slot = mid;
        return 1'b1;
      end
    end
    slot = lo;
    return 1'b0;
  endfunction

  function automatic logic [31:0] take_entry(input int p);
    logic [31:0] k;
    int          i;
    k = tbl_keys[p];
    for (i = p; i + 1 < tbl_count; i++) tbl_keys[i] = tbl_keys[i + 1];
    tbl_count--;
    return k;
  endfunction

  function automatic out_t apply_table_op(input in_t it);
    out_t res;
    int   slot;
    int   i;
    res = '0;
    case (it.op)
      OP_INSERT: begin
        if (search_slot(it.key, slot)) begin
          res.status         = ST_DUP;
          res.found_position = slot[7:0];
          res.found_key      = it.key;
        end else if (tbl_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = tbl_count; i > slot; i--) tbl_keys[i] = tbl_keys[i - 1];
          tbl_keys[slot] = it.key;
          tbl_count++;
          res.found_position = slot[7:0];
          res.found_key      = it.key;
        end
      end
      OP_FIND, OP_REMOVE_KEY: begin
        if (search_slot(it.key, slot)) begin
          res.found_position = slot[7:0];
          res.found_key      = (it.op == OP_FIND) ? tbl_keys[slot] : take_entry(slot);
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      OP_REMOVE_POS, OP_READ: begin
        if (int'(it.position) >= tbl_count) begin
          res.status = ST_BADPOS;
        end else begin
          res.found_position = it.position;
          res.found_key      = (it.op == OP_READ) ? tbl_keys[it.position]
                                                  : take_entry(it.position);
        end
      end
      OP_APPEND: begin
        if (tbl_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          tbl_keys[tbl_count] = it.key;
          res.found_position  = tbl_count[7:0];
          res.found_key       = it.key;
          tbl_count++;
        end
      end
      default: ;
    endcase
    res.count = tbl_count[8:0];
    return res;
  endfunction

  // mostly back to back, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_key(input bit from_table);
    int r;
    if (from_table && tbl_count > 0) return tbl_keys[$urandom_range(0, tbl_count - 1)];
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h0000_0000;
    if (r < 6) return 32'hFFFF_FFFF;
    if (r < 25) return $urandom_range(0, 255);
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (tbl_count > 0 && r < 80) return 8'($urandom_range(0, tbl_count - 1));
    if (tbl_count < DEPTH && r < 95) return 8'($urandom_range(tbl_count, DEPTH - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one item, book its result at acceptance, then idle at random
  task automatic offer_item(input in_t it, input logic typed, input out_t want);
    out_t pred;
    int   gap;
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = apply_table_op(it);
    pending_results.push_back(typed ? want : pred);
    status_seen[pred.status]++;
    if (tbl_count > peak_count) peak_count = tbl_count;
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // receiver: random stalls, quiet stretches, and one long hold on request
  initial begin : receiver_stall
    int run_left;
    int stall_left;
    run_left   = 0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        run_left   = 0;
        stall_left = HOLD_CYCLES;
      end
      if (run_left == 0 && stall_left == 0) begin
        run_left   = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150) : 1 + pick_gap();
        stall_left = pick_gap();
      end
      if (run_left > 0) begin
        out_stall_i <= 1'b0;
        run_left--;
      end else begin
        out_stall_i <= 1'b1;
        stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", out_o));
      end else begin
        want = pending_results.pop_front();
        if (out_o.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    results_checked, out_o.status, want.status));
        if (out_o.found_position !== want.found_position)
          report_mismatch($sformatf("result %0d position %0d, want %0d", results_checked,
                                    out_o.found_position, want.found_position));
        if (out_o.found_key !== want.found_key)
          report_mismatch($sformatf("result %0d key %h, want %h",
                                    results_checked, out_o.found_key, want.found_key));
        if (out_o.count !== want.count)
          report_mismatch($sformatf("result %0d count %0d, want %0d",
                                    results_checked, out_o.count, want.count));
      end
      results_checked++;
    end
  end

  initial begin : stimulus
    in_t it;
    int  i;
    int  r;
    bit  growing;
    int  full_items;

    directed_rows = '{
      // empty table
      {OP_FIND,       32'h0000_0000, 8'd0,   1'b1, ST_NOTFOUND, 8'd0, 32'h0000_0000, 9'd0},
      {OP_READ,       32'h0000_0000, 8'd0,   1'b1, ST_BADPOS,   8'd0, 32'h0000_0000, 9'd0},
      {OP_REMOVE_POS, 32'hFFFF_FFFF, 8'd0,   1'b1, ST_BADPOS,   8'd0, 32'h0000_0000, 9'd0},
      {OP_REMOVE_KEY, 32'h0000_0005, 8'd255, 1'b1, ST_NOTFOUND, 8'd0, 32'h0000_0000, 9'd0},
      // key extremes, then a duplicate
      {OP_INSERT,     32'h8000_0000, 8'd0,   1'b1, ST_OK,       8'd0, 32'h8000_0000, 9'd1},
      {OP_INSERT,     32'h0000_0000, 8'd0,   1'b1, ST_OK,       8'd0, 32'h0000_0000, 9'd2},
      {OP_INSERT,     32'hFFFF_FFFF, 8'd0,   1'b1, ST_OK,       8'd2, 32'hFFFF_FFFF, 9'd3},
      {OP_INSERT,     32'h8000_0000, 8'd0,   1'b1, ST_DUP,      8'd1, 32'h8000_0000, 9'd3},
      {OP_FIND,       32'hFFFF_FFFF, 8'd0,   1'b1, ST_OK,       8'd2, 32'hFFFF_FFFF, 9'd3},
      {OP_READ,       32'h0000_0000, 8'd255, 1'b1, ST_BADPOS,   8'd0, 32'h0000_0000, 9'd3},
      {OP_READ,       32'h0000_0000, 8'd1,   1'b1, ST_OK,       8'd1, 32'h8000_0000, 9'd3},
      {OP_SPARE_6,    32'h1234_5678, 8'hAA,  1'b1, ST_OK,       8'd0, 32'h0000_0000, 9'd3},
      {OP_SPARE_7,    32'hFFFF_FFFF, 8'hFF,  1'b1, ST_OK,       8'd0, 32'h0000_0000, 9'd3},
      // append breaks the order; later searches follow the same probes anyway
      {OP_APPEND,     32'h0000_0010, 8'd0,   1'b1, ST_OK,       8'd3, 32'h0000_0010, 9'd4},
      {OP_FIND,       32'h0000_0010, 8'd0,   1'b0, ST_OK,       8'd0, 32'h0000_0000, 9'd0},
      {OP_INSERT,     32'h0000_0020, 8'd0,   1'b0, ST_OK,       8'd0, 32'h0000_0000, 9'd0},
      {OP_REMOVE_KEY, 32'h0000_0000, 8'd0,   1'b0, ST_OK,       8'd0, 32'h0000_0000, 9'd0},
      {OP_REMOVE_POS, 32'h0000_0000, 8'd1,   1'b0, ST_OK,       8'd0, 32'h0000_0000, 9'd0},
      {OP_REMOVE_KEY, 32'hFFFF_FFFF, 8'd0,   1'b0, ST_OK,       8'd0, 32'h0000_0000, 9'd0},
      {OP_READ,       32'h0000_0000, 8'd0,   1'b0, ST_OK,       8'd0, 32'h0000_0000, 9'd0},
      {OP_APPEND,     32'h7FFF_FFFF, 8'd0,   1'b0, ST_OK,       8'd0, 32'h0000_0000, 9'd0},
      {OP_INSERT,     32'h7FFF_FFFF, 8'd0,   1'b0, ST_OK,       8'd0, 32'h0000_0000, 9'd0},
      {OP_REMOVE_POS, 32'h0000_0000, 8'd0,   1'b0, ST_OK,       8'd0, 32'h0000_0000, 9'd0},
      {OP_FIND,       32'h7FFF_FFFF, 8'd0,   1'b0, ST_OK,       8'd0, 32'h0000_0000, 9'd0}
    };

    tbl_count  = 0;
    peak_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_DIRECTED; i++)
      offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // hold the output early on so the block backs up onto its input
    hold_req   = 1'b1;
    growing    = 1'b1;
    full_items = 0;
    for (i = 0; i < N_RANDOM; i++) begin
      if (growing && tbl_count == DEPTH) begin
        full_items++;
        if (full_items >= 8) begin
          growing    = 1'b0;
          full_items = 0;
        end
      end
      if (!growing && tbl_count <= 4) growing = 1'b1;

      it.key      = pick_key(1'b0);
      it.position = pick_position();
      r           = $urandom_range(0, 99);
      if (growing) begin
        if (r < 66) begin
          it.op  = OP_INSERT;
          it.key = pick_key($urandom_range(0, 9) == 0);
        end else if (r < 86) begin
          it.op = OP_APPEND;
          // keep most appends in order so searches stay meaningful
          if (tbl_count > 0 && $urandom_range(0, 3) != 0 &&
              tbl_keys[tbl_count - 1] < 32'hFFFF_E000)
            it.key = tbl_keys[tbl_count - 1] + $urandom_range(1, 4096);
        end else if (r < 90) begin
          it.op  = OP_FIND;
          it.key = pick_key($urandom_range(0, 1) != 0);
        end else if (r < 93) begin
          it.op = OP_READ;
        end else if (r < 95) begin
          it.op  = OP_REMOVE_KEY;
          it.key = pick_key($urandom_range(0, 1) != 0);
        end else if (r < 97) begin
          it.op = OP_REMOVE_POS;
        end else begin
          it.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
      end else begin
        if (r < 35) begin
          it.op  = OP_REMOVE_KEY;
          it.key = pick_key($urandom_range(0, 4) != 0);
        end else if (r < 70) begin
          it.op = OP_REMOVE_POS;
        end else if (r < 80) begin
          it.op  = OP_FIND;
          it.key = pick_key($urandom_range(0, 9) < 7);
        end else if (r < 90) begin
          it.op = OP_READ;
        end else if (r < 95) begin
          it.op  = OP_INSERT;
          it.key = pick_key($urandom_range(0, 1) != 0);
        end else if (r < 98) begin
          it.op = OP_APPEND;
        end else begin
          it.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
      end
      offer_item(it, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("covered %0d items and %0d results; table peaked at %0d of %0d entries",
             items_sent, results_checked, peak_count, DEPTH);
    $display("outcomes: ok %0d, duplicate %0d, not found %0d, full %0d, bad position %0d",
             status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_NOTFOUND],
             status_seen[ST_FULL], status_seen[ST_BADPOS]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sorted_key_table_unit.f */
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/skt_group.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table_unit.sv
rtl/skt_checker.sv
tb/sorted_key_table_unit_tb.sv
